// ===== rtl/preboot_write_command_framer_top_defines.svh =====
// Assertion helpers, clocked on clk with active-low rst_n.
`ifndef PREBOOT_WRITE_COMMAND_FRAMER_TOP_DEFINES_SVH
`define PREBOOT_WRITE_COMMAND_FRAMER_TOP_DEFINES_SVH

// Checked only out of reset.
`define PWCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset too.
`define PWCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pwcf_pkg.sv =====
package pwcf_pkg;

  localparam logic [1:0] FUNC_PASS   = 2'd0;
  localparam logic [1:0] FUNC_START  = 2'd1;
  localparam logic [1:0] FUNC_IMAGE  = 2'd2;
  localparam logic [1:0] FUNC_FINISH = 2'd3;

  localparam logic [31:0] STOP_RESET   = 32'h0861_0040;
  localparam logic [31:0] WIN_REG_ADDR = 32'h0957_0158;
  localparam logic [31:0] WAIT_ADDR    = 32'h0961_00C0;
  localparam logic [31:0] WAIT_COUNT   = 32'h000F_FFFF;

  localparam int unsigned CFG_AW = 3;
  localparam logic CFG_IDX_STOP = 1'b0;

  typedef enum logic [2:0] {
    SEL_DATA,
    SEL_WIN,
    SEL_DEST,
    SEL_WAITA,
    SEL_WAITC,
    SEL_CHUNK,
    SEL_STOP,
    SEL_CRC
  } sel_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic       last;
    logic       fold;
    logic       clear;
    sel_t       sel;
    logic [1:0] lane;
  } cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic left_zero;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/pwcf_if.sv =====
interface pwcf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic [31:0] dest_address;
  logic [31:0] image_length;

  modport source (output valid, func, data_byte, dest_address, image_length, input ready);
  modport sink (input valid, func, data_byte, dest_address, image_length, output ready);
endinterface

interface pwcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

// ===== rtl/pwcf_dp.sv =====
module pwcf_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  pwcf_pkg::cmd_t   cmd,
  output pwcf_pkg::status_t status,
  input  logic [1:0]       in_func,
  input  logic [7:0]       in_data_byte,
  input  logic [31:0]      in_dest_address,
  input  logic [31:0]      in_image_length,
  input  logic [31:0]      stop_command,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last
);
  import pwcf_pkg::*;

  function automatic logic [6:0] chunk_size(input logic [31:0] rem);
    logic [6:0] s;
    s = 7'd1;
    priority if (|rem[31:6]) s = 7'd64;
    else if (rem[5]) s = 7'd32;
    else if (rem[4]) s = 7'd16;
    else if (rem[3]) s = 7'd8;
    else if (rem[2]) s = 7'd4;
    else if (rem[1]) s = 7'd2;
    else s = 7'd1;
    return s;
  endfunction

  function automatic logic [31:0] chunk_base(input logic [6:0] s);
    logic [31:0] b;
    unique case (s)
      7'd32:   b = 32'hC100_0000;
      7'd16:   b = 32'hA100_0000;
      7'd8:    b = 32'h9100_0000;
      7'd4:    b = 32'h8900_0000;
      7'd2:    b = 32'h8500_0000;
      7'd1:    b = 32'h8200_0000;
      default: b = 32'h8100_0000;
    endcase
    return b;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ 32'h04C1_1DB7) : (c << 1);
    end
    return c;
  endfunction

  logic [31:0] crc_r,   crc_nxt;
  logic [31:0] rem_r,   rem_nxt;
  logic [23:0] off_r,   off_nxt;
  logic [6:0]  left_r,  left_nxt;
  logic [7:0]  data_r;
  logic [11:0] desthi_r;
  logic [31:0] chunk_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic [6:0]  size;
  logic [31:0] word;
  logic [7:0]  byte_sel;

  assign size = chunk_size(rem_r);

  assign status.rem_zero  = (rem_r == 32'd0);
  assign status.left_zero = (left_r == 7'd0);
  assign status.out_free  = !out_valid_r || out_ready;

  always_comb begin
    unique case (cmd.sel)
      SEL_WIN:   word = WIN_REG_ADDR;
      SEL_DEST:  word = {16'h0, desthi_r, 4'h0};
      SEL_WAITA: word = WAIT_ADDR;
      SEL_WAITC: word = WAIT_COUNT;
      SEL_CHUNK: word = chunk_r;
      SEL_STOP:  word = stop_command;
      SEL_CRC:   word = crc_r;
      default:   word = {24'h0, data_r};
    endcase
    if (cmd.sel == SEL_DATA) begin
      byte_sel = data_r;
    end else begin
      unique case (cmd.lane)
        2'd0:    byte_sel = word[31:24];
        2'd1:    byte_sel = word[23:16];
        2'd2:    byte_sel = word[15:8];
        default: byte_sel = word[7:0];
      endcase
    end
  end

  always_comb begin
    crc_nxt  = crc_r;
    rem_nxt  = rem_r;
    off_nxt  = off_r;
    left_nxt = left_r;
    if (cmd.load) begin
      unique case (in_func)
        FUNC_START: begin
          rem_nxt  = in_image_length;
          off_nxt  = in_dest_address[23:0];
          left_nxt = 7'd0;
        end
        FUNC_IMAGE: begin
          if (!status.rem_zero) begin
            if (status.left_zero) begin
              off_nxt  = off_r + {17'h0, size};
              left_nxt = size - 7'd1;
            end else begin
              left_nxt = left_r - 7'd1;
            end
            rem_nxt = rem_r - 32'd1;
          end
        end
        default: ;
      endcase
    end
    if (cmd.emit && cmd.fold) begin
      crc_nxt = crc_byte(crc_r, byte_sel);
    end
    if (cmd.emit && cmd.clear) begin
      crc_nxt  = '1;
      rem_nxt  = '0;
      off_nxt  = '0;
      left_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '1;
      rem_r       <= '0;
      off_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      rem_r  <= rem_nxt;
      off_r  <= off_nxt;
      left_r <= left_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_r <= in_data_byte;
      if (in_func == FUNC_START) begin
        desthi_r <= in_dest_address[31:20];
      end
      if (in_func == FUNC_IMAGE && status.left_zero) begin
        chunk_r <= chunk_base(size) | {8'h0, off_r};
      end
    end
    if (cmd.emit) begin
      out_byte_r <= byte_sel;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// ===== rtl/pwcf_ctrl.sv =====
`include "preboot_write_command_framer_top_defines.svh"

module pwcf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  pwcf_pkg::status_t status,
  output pwcf_pkg::cmd_t    cmd
);
  import pwcf_pkg::*;

  typedef enum logic {S_IDLE, S_EMIT} state_t;
  typedef enum logic [2:0] {K_PASS, K_START, K_HDR, K_IMG, K_FIN} kind_t;

  state_t     state_r;
  kind_t      kind_r;
  logic [3:0] cnt_r;
  logic [3:0] last_cnt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    cmd.load  = accept;
    cmd.emit  = (state_r == S_EMIT) && status.out_free;
    cmd.sel   = SEL_DATA;
    cmd.lane  = cnt_r[1:0];
    cmd.fold  = 1'b1;
    unique case (kind_r)
      K_START: begin
        last_cnt = 4'd15;
        unique case (cnt_r[3:2])
          2'd0:    cmd.sel = SEL_WIN;
          2'd1:    cmd.sel = SEL_DEST;
          2'd2:    cmd.sel = SEL_WAITA;
          default: cmd.sel = SEL_WAITC;
        endcase
      end
      K_HDR: begin
        last_cnt = 4'd4;
        cmd.sel  = cnt_r[2] ? SEL_DATA : SEL_CHUNK;
      end
      K_FIN: begin
        last_cnt = 4'd7;
        cmd.sel  = cnt_r[2] ? SEL_CRC : SEL_STOP;
        cmd.fold = !cnt_r[2];
      end
      default: last_cnt = 4'd0;
    endcase
    cmd.last  = (cnt_r == last_cnt);
    cmd.clear = (kind_r == K_FIN) && cmd.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= K_PASS;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cnt_r <= '0;
            unique case (in_func)
              FUNC_PASS: begin
                kind_r  <= K_PASS;
                state_r <= S_EMIT;
              end
              FUNC_START: begin
                kind_r  <= K_START;
                state_r <= S_EMIT;
              end
              FUNC_IMAGE: begin
                if (!status.rem_zero) begin
                  kind_r  <= status.left_zero ? K_HDR : K_IMG;
                  state_r <= S_EMIT;
                end
              end
              default: begin
                kind_r  <= K_FIN;
                state_r <= S_EMIT;
              end
            endcase
          end
        end
        default: begin
          if (cmd.emit) begin
            if (cmd.last) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r + 4'd1;
            end
          end
        end
      endcase
    end
  end

  `PWCF_ASSERT(a_emit_free, cmd.emit |-> status.out_free, "beat pushed into a full output register")
  `PWCF_ASSERT(a_last_idle, (cmd.emit && cmd.last) |=> in_ready, "not idle after last beat")
  `PWCF_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (in_ready && !cmd.emit), "busy after reset")

endmodule

// ===== rtl/preboot_write_command_framer_top.sv =====
// Pre-boot command stream framer. Every accepted item is turned into a run
// of bytes on the output channel, one byte per cycle while the output is not
// stalled, the final one flagged by last_of_run. Pass byte gives 1 byte, copy
// start 16, image byte 1 (5 when it opens a chunk), finish 8; an image byte
// with no image pending gives none. No new item is taken until the current
// one's last byte is emitted. Every byte but the trailing CRC word is folded
// into a 32-bit CRC (poly 04C11DB7, all-ones start, MSB first, not inverted)
// as it leaves. stop_command sits at byte address 0 of the APB port.
module preboot_write_command_framer_top (
  input  logic                       clk,
  input  logic                       rst_n,
  pwcf_in_if.sink                    in_ch,
  pwcf_out_if.source                 out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [pwcf_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import pwcf_pkg::*;

  logic [31:0] stop_r;
  cmd_t        cmd;
  status_t     status;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_STOP) ? stop_r : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= STOP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == CFG_IDX_STOP) begin
      stop_r <= cfg_pwdata;
    end
  end

  pwcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_func  (in_ch.func),
    .status   (status),
    .cmd      (cmd)
  );

  pwcf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_func         (in_ch.func),
    .in_data_byte    (in_ch.data_byte),
    .in_dest_address (in_ch.dest_address),
    .in_image_length (in_ch.image_length),
    .stop_command    (stop_r),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_byte        (out_ch.out_byte),
    .out_last        (out_ch.last_of_run)
  );

endmodule

// ===== sim/framer_checker.sv =====
module framer_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  pwcf_in_if                           in_mon,
  pwcf_out_if                          out_mon,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pwcf_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  input  logic                         cfg_pready,
  output int                           fail_count,
  output int                           pending,
  output int                           checked
);
  import pwcf_pkg::*;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [31:0] CMD_W64 = 32'h8100_0000;
  localparam logic [31:0] CMD_W32 = 32'hC100_0000;
  localparam logic [31:0] CMD_W16 = 32'hA100_0000;
  localparam logic [31:0] CMD_W8  = 32'h9100_0000;
  localparam logic [31:0] CMD_W4  = 32'h8900_0000;
  localparam logic [31:0] CMD_W2  = 32'h8500_0000;
  localparam logic [31:0] CMD_W1  = 32'h8200_0000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } stream_byte_t;

  stream_byte_t stream_q[$];

  logic [31:0] stop_word;
  logic [31:0] crc;
  logic [31:0] img_left;
  logic [23:0] wr_offset;
  logic [6:0]  chunk_left;

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    int k;
    r = c ^ {b, 24'h0};
    for (k = 0; k < 8; k++) r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  function automatic logic [7:0] chunk_len(input logic [31:0] rem);
    if (rem >= 64) return 8'd64;
    if (rem >= 32) return 8'd32;
    if (rem >= 16) return 8'd16;
    if (rem >= 8) return 8'd8;
    if (rem >= 4) return 8'd4;
    if (rem >= 2) return 8'd2;
    return 8'd1;
  endfunction

  function automatic logic [31:0] chunk_cmd(input logic [7:0] sz);
    case (sz)
      8'd32: return CMD_W32;
      8'd16: return CMD_W16;
      8'd8: return CMD_W8;
      8'd4: return CMD_W4;
      8'd2: return CMD_W2;
      8'd1: return CMD_W1;
      default: return CMD_W64;
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic fold);
    stream_byte_t e;
    if (fold) crc = crc_next(crc, b);
    e.out_byte = b;
    e.last_of_run = 1'b0;
    stream_q.push_back(e);
  endtask

  task automatic push_word(input logic [31:0] w, input logic fold);
    push_byte(w[31:24], fold);
    push_byte(w[23:16], fold);
    push_byte(w[15:8], fold);
    push_byte(w[7:0], fold);
  endtask

  task automatic clear_stream();
    crc = CRC_INIT;
    img_left = '0;
    wr_offset = '0;
    chunk_left = '0;
  endtask

  task automatic frame_item(input logic [1:0] f, input logic [7:0] d,
                            input logic [31:0] dest, input logic [31:0] len);
    int first;
    logic [7:0] sz;
    logic [31:0] crc_snap;
    first = stream_q.size();
    case (f)
      FUNC_PASS: push_byte(d, 1'b1);
      FUNC_START: begin
        push_word(WIN_REG_ADDR, 1'b1);
        push_word({16'h0, dest[31:20], 4'h0}, 1'b1);
        push_word(WAIT_ADDR, 1'b1);
        push_word(WAIT_COUNT, 1'b1);
        img_left = len;
        wr_offset = dest[23:0];
        chunk_left = '0;
      end
      FUNC_IMAGE: begin
        if (img_left != 0) begin
          if (chunk_left == 0) begin
            sz = chunk_len(img_left);
            push_word(chunk_cmd(sz) | {8'h0, wr_offset}, 1'b1);
            wr_offset = wr_offset + {16'h0, sz};
            chunk_left = sz[6:0];
          end
          push_byte(d, 1'b1);
          chunk_left = chunk_left - 7'd1;
          img_left = img_left - 32'd1;
        end
      end
      default: begin
        push_word(stop_word, 1'b1);
        crc_snap = crc;
        push_word(crc_snap, 1'b0);
        clear_stream();
      end
    endcase
    if (stream_q.size() > first) stream_q[stream_q.size() - 1].last_of_run = 1'b1;
  endtask

  always @(posedge clk) begin
    stream_byte_t want;
    if (!rst_n) begin
      stop_word = STOP_RESET;
      clear_stream();
      stream_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
          && cfg_paddr[2] == CFG_IDX_STOP)
        stop_word = cfg_pwdata;
      if (in_mon.valid && in_mon.ready)
        frame_item(in_mon.func, in_mon.data_byte, in_mon.dest_address, in_mon.image_length);
      if (out_mon.valid && out_mon.ready) begin
        if (stream_q.size() == 0) begin
          $error("unexpected beat: out_byte %02h last_of_run %0b",
                 out_mon.out_byte, out_mon.last_of_run);
          fail_count++;
        end else begin
          want = stream_q.pop_front();
          checked++;
          if (out_mon.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_mon.out_byte);
            fail_count++;
          end
          if (out_mon.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   out_mon.last_of_run);
            fail_count++;
          end
        end
      end
    end
    pending = stream_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import pwcf_pkg::*;

  localparam logic [CFG_AW-1:0] STOP_ADDR    = CFG_AW'(4 * CFG_IDX_STOP);
  localparam logic [CFG_AW-1:0] UNUSED_ADDR  = CFG_AW'(4 * (CFG_IDX_STOP + 1));
  localparam int                IDLE_LIMIT   = 4000;
  localparam int                SETTLE       = 40;
  localparam int                HOLD_CYCLES  = 300;
  localparam int                PHASE_ITEMS  = 62;

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int fail_count;
  int pending;
  int checked;
  int items_sent;
  int src_idle_pct;
  int sink_stall_pct;
  int hold_req;

  pwcf_in_if  in_ch();
  pwcf_out_if out_ch();

  preboot_write_command_framer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  framer_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_pready (cfg_pready),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_psel && cfg_penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  task automatic drive_item(input logic [1:0] f, input logic [7:0] d,
                            input logic [31:0] dest, input logic [31:0] len);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.func = f;
    in_ch.data_byte = d;
    in_ch.dest_address = dest;
    in_ch.image_length = len;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [31:0] value);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = addr;
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // mostly complete copy sequences, some cut short, some plain noise
  task automatic random_items(input int quota);
    int stop_at;
    int len;
    int n;
    int r;
    logic cut;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 78) begin
        r = $urandom_range(9);
        if (r < 6) len = $urandom_range(0, 20);
        else if (r < 9) len = $urandom_range(21, 70);
        else len = $urandom_range(64, 100);
        drive_item(FUNC_START, 8'($urandom), $urandom, len);
        n = 0;
        cut = 1'b0;
        while (n < len && !cut && items_sent < stop_at) begin
          if ($urandom_range(19) == 0)
            drive_item(FUNC_PASS, 8'($urandom), $urandom, $urandom);
          if ($urandom_range(49) == 0) begin
            cut = 1'b1;
          end else begin
            drive_item(FUNC_IMAGE, 8'($urandom), $urandom, $urandom);
            n++;
          end
        end
        if (!cut || $urandom_range(1) == 0)
          drive_item(FUNC_FINISH, 8'($urandom), $urandom, $urandom);
      end else begin
        drive_item(2'($urandom_range(3)), 8'($urandom), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    logic [31:0] stop_val;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_PASS;
    in_ch.data_byte = '0;
    in_ch.dest_address = '0;
    in_ch.image_length = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    items_sent = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_req = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed, reset stop command
    drive_item(FUNC_PASS, 8'h00, 32'h0, 32'h0);
    drive_item(FUNC_PASS, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_item(FUNC_IMAGE, 8'hA5, 32'h0, 32'h0);            // stray, dropped
    drive_item(FUNC_START, 8'h00, 32'hFFFF_FFFF, 32'h0);    // header only
    drive_item(FUNC_IMAGE, 8'h5A, 32'h0, 32'h0);            // stray after empty copy
    drive_item(FUNC_START, 8'h00, 32'h0000_0000, 32'd3);
    drive_item(FUNC_IMAGE, 8'h01, 32'h0, 32'h0);
    drive_item(FUNC_PASS, 8'h77, 32'h0, 32'h0);             // pass inside a chunk
    drive_item(FUNC_IMAGE, 8'h02, 32'h0, 32'h0);
    drive_item(FUNC_IMAGE, 8'h03, 32'h0, 32'h0);
    drive_item(FUNC_FINISH, 8'h00, 32'h0, 32'h0);
    drive_item(FUNC_START, 8'h00, 32'hABFF_FFFF, 32'd3);    // offset wraps
    drive_item(FUNC_IMAGE, 8'hC3, 32'h0, 32'h0);
    drive_item(FUNC_IMAGE, 8'h3C, 32'h0, 32'h0);
    drive_item(FUNC_IMAGE, 8'h81, 32'h0, 32'h0);
    drive_item(FUNC_START, 8'h00, 32'h00FF_FFC0, 32'hFFFF_FFFF);
    drive_item(FUNC_IMAGE, 8'h11, 32'h0, 32'h0);
    drive_item(FUNC_IMAGE, 8'h22, 32'h0, 32'h0);
    drive_item(FUNC_START, 8'h00, 32'h1234_5678, 32'd5);   // restart mid image
    repeat (5) drive_item(FUNC_IMAGE, 8'($urandom), 32'h0, 32'h0);
    drive_item(FUNC_FINISH, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_item(FUNC_FINISH, 8'h00, 32'h0, 32'h0);           // finish on clean state

    // no idling, long receiver hold-off
    hold_req++;
    random_items(PHASE_ITEMS);
    drain();

    cfg_write(STOP_ADDR, 32'hFFFF_FFFF);
    src_idle_pct = 71;
    sink_stall_pct = 0;
    random_items(PHASE_ITEMS);
    drain();

    cfg_write(STOP_ADDR, 32'h0000_0000);
    src_idle_pct = 0;
    sink_stall_pct = 71;
    random_items(PHASE_ITEMS);
    drain();

    cfg_write(STOP_ADDR, $urandom);
    src_idle_pct = 24;
    sink_stall_pct = 24;
    random_items(PHASE_ITEMS);
    drain();

    stop_val = $urandom;
    cfg_write(STOP_ADDR, stop_val);
    cfg_write(UNUSED_ADDR, ~stop_val);                      // no such register
    src_idle_pct = 0;
    sink_stall_pct = 0;
    random_items(PHASE_ITEMS / 2);
    drain();
    cfg_write(STOP_ADDR, STOP_RESET);
    random_items(PHASE_ITEMS / 2);
    drain();

    $display("Run covered %0d input items and %0d checked output beats,", items_sent, checked);
    $display("directed corners, five pacing phases and stop commands incl. all-ones and zero.");
    if (fail_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
